// ----- src/dtp_pkg.sv -----
// shared types, constants and helper functions for the dominant tone picker
`default_nettype none

package dtp_pkg;

    localparam int NUM_LANES = 4;
    localparam int NUM_W     = 23;
    localparam int DVR_W     = 20;
    localparam int REG_W     = 20;
    localparam int TONE_W    = 21;
    localparam int PER_W     = 11;
    localparam int VOL_W     = 4;
    localparam int SHIFT_W   = 4;
    localparam int CODE_W    = 3;
    localparam int BASE_W    = 7;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 24;

    // one quotient bit per stage
    localparam int DIV_STAGES = NUM_W;

    localparam int LANE_SQ1   = 0;
    localparam int LANE_SQ2   = 1;
    localparam int LANE_WAVE  = 2;
    localparam int LANE_NOISE = 3;

    localparam logic [NUM_W-1:0]   TONE_NUM   = NUM_W'(1048576);
    localparam logic [NUM_W-1:0]   NOISE_NUM  = NUM_W'(4194304);
    localparam logic [PER_W:0]     PERIOD_SPAN = (PER_W+1)'(2048);
    localparam logic [PER_W-1:0]   PERIOD_MIN = PER_W'(8);
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = SHIFT_W'(13);

    localparam logic [REG_W-1:0] BAND_LOW_RST  = REG_W'(80);
    localparam logic [REG_W-1:0] BAND_HIGH_RST = REG_W'(3500);
    localparam logic [REG_W-1:0] RATTLE_RST    = REG_W'(200);

    typedef enum logic [1:0] {
        CFG_BAND_LOW  = 2'd0,
        CFG_BAND_HIGH = 2'd1,
        CFG_RATTLE    = 2'd2
    } cfg_idx_t;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DVR_W-1:0] dvr_t;

    typedef struct packed {
        logic [DVR_W-1:0] rem;
        logic [NUM_W-1:0] dvd;
        logic [NUM_W-1:0] quo;
        logic [DVR_W-1:0] dvr;
    } div_stage_t;

    typedef struct packed {
        logic             master_on;
        logic             sq1_ok;
        logic [VOL_W-1:0] sq1_vol;
        logic             sq2_ok;
        logic [VOL_W-1:0] sq2_vol;
        logic             wave_ok;
        logic             noise_on;
        logic             shift_ok;
    } side_t;

    typedef struct packed {
        logic [REG_W-1:0] band_low;
        logic [REG_W-1:0] band_high;
        logic [REG_W-1:0] rattle;
    } cfg_t;

    // divisor code to base divisor
    function automatic logic [BASE_W-1:0] noise_base(input logic [CODE_W-1:0] code);
        logic [BASE_W-1:0] b;
        case (code)
            3'd0:    b = BASE_W'(8);
            3'd1:    b = BASE_W'(16);
            3'd2:    b = BASE_W'(32);
            3'd3:    b = BASE_W'(48);
            3'd4:    b = BASE_W'(64);
            3'd5:    b = BASE_W'(80);
            3'd6:    b = BASE_W'(96);
            default: b = BASE_W'(112);
        endcase
        return b;
    endfunction

    // one restoring division step
    function automatic div_stage_t div_step(input div_stage_t s);
        logic [DVR_W:0] trial;
        logic [DVR_W:0] diff;
        div_stage_t     r;
        r     = s;
        trial = {s.rem, s.dvd[NUM_W-1]};
        diff  = trial - {1'b0, s.dvr};
        if (trial >= {1'b0, s.dvr})
        begin
            r.rem = diff[DVR_W-1:0];
            r.quo = {s.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DVR_W-1:0];
            r.quo = {s.quo[NUM_W-2:0], 1'b0};
        end
        r.dvd = {s.dvd[NUM_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/dtp_prep.sv -----
// unpacks an input item into lane dividends, divisors and selection flags
`default_nettype none

module dtp_prep
    import dtp_pkg::*;
(
    input  wire logic [IN_W-1:0] s_tdata,
    output num_t                 dividend [NUM_LANES],
    output dvr_t                 divisor  [NUM_LANES],
    output side_t                side
);

    logic               master_on;
    logic               sq1_active;
    logic [VOL_W-1:0]   sq1_volume;
    logic [PER_W-1:0]   sq1_period;
    logic               sq2_active;
    logic [VOL_W-1:0]   sq2_volume;
    logic [PER_W-1:0]   sq2_period;
    logic               wave_active;
    logic [PER_W-1:0]   wave_period;
    logic               noise_active;
    logic [SHIFT_W-1:0] noise_shift;
    logic [CODE_W-1:0]  noise_div_code;
    logic [DVR_W-1:0]   noise_dvr;

    assign master_on      = s_tdata[0];
    assign sq1_active     = s_tdata[1];
    assign sq1_volume     = s_tdata[5:2];
    assign sq1_period     = s_tdata[16:6];
    assign sq2_active     = s_tdata[17];
    assign sq2_volume     = s_tdata[21:18];
    assign sq2_period     = s_tdata[32:22];
    assign wave_active    = s_tdata[33];
    assign wave_period    = s_tdata[44:34];
    assign noise_active   = s_tdata[45];
    assign noise_shift    = s_tdata[49:46];
    assign noise_div_code = s_tdata[52:50];

    // shifts above the limit overflow here, but that lane then gives a zero tone
    assign noise_dvr = {{(DVR_W-BASE_W){1'b0}}, noise_base(noise_div_code)} << noise_shift;

    always_comb
    begin
        dividend[LANE_SQ1]   = TONE_NUM;
        dividend[LANE_SQ2]   = TONE_NUM;
        dividend[LANE_WAVE]  = TONE_NUM;
        dividend[LANE_NOISE] = NOISE_NUM;
        divisor[LANE_SQ1]    = DVR_W'(PERIOD_SPAN - {1'b0, sq1_period});
        divisor[LANE_SQ2]    = DVR_W'(PERIOD_SPAN - {1'b0, sq2_period});
        divisor[LANE_WAVE]   = DVR_W'(PERIOD_SPAN - {1'b0, wave_period});
        divisor[LANE_NOISE]  = noise_dvr;
    end

    always_comb
    begin
        side.master_on = master_on;
        side.sq1_ok    = sq1_active && (sq1_volume != '0) && (sq1_period >= PERIOD_MIN);
        side.sq1_vol   = sq1_volume;
        side.sq2_ok    = sq2_active && (sq2_volume != '0) && (sq2_period >= PERIOD_MIN);
        side.sq2_vol   = sq2_volume;
        side.wave_ok   = wave_active && (wave_period >= PERIOD_MIN);
        side.noise_on  = noise_active;
        side.shift_ok  = noise_shift <= SHIFT_MAX;
    end

endmodule

`default_nettype wire

// ----- src/dtp_div_lane.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module dtp_div_lane
    import dtp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [DIV_STAGES-1:0] en,
    input  num_t                       dividend,
    input  dvr_t                       divisor,
    output num_t                       quotient
);

    div_stage_t stage_reg [DIV_STAGES];
    div_stage_t stage_in  [DIV_STAGES];

    always_comb
    begin
        stage_in[0].rem = '0;
        stage_in[0].dvd = dividend;
        stage_in[0].quo = '0;
        stage_in[0].dvr = divisor;
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            stage_in[j] = stage_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                stage_reg[j] <= div_step(stage_in[j]);
            end
        end
    end

    assign quotient = stage_reg[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ----- src/dtp_merge.sv -----
// combines the lane quotients into one tone and holds the output register
`default_nettype none

module dtp_merge
    import dtp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         en,
    input  side_t             side,
    input  num_t              quotient [NUM_LANES],
    input  cfg_t              cfg,
    output logic [TONE_W-1:0] tone
);

    logic [TONE_W-1:0] tone_reg;
    logic [TONE_W-1:0] tone_next;
    logic              pick_sq2;
    logic              in_band;
    logic [TONE_W-1:0] noise_tone;

    assign pick_sq2 = side.sq2_ok && (!side.sq1_ok || (side.sq2_vol >= side.sq1_vol));
    assign in_band  = (quotient[LANE_NOISE] >= {{(NUM_W-REG_W){1'b0}}, cfg.band_low})
                   && (quotient[LANE_NOISE] <= {{(NUM_W-REG_W){1'b0}}, cfg.band_high});

    always_comb
    begin
        if (!side.shift_ok)
            noise_tone = '0;
        else if (in_band)
            noise_tone = quotient[LANE_NOISE][TONE_W-1:0];
        else
            noise_tone = {{(TONE_W-REG_W){1'b0}}, cfg.rattle};
    end

    always_comb
    begin
        if (!side.master_on)
            tone_next = '0;
        else if (pick_sq2)
            tone_next = quotient[LANE_SQ2][TONE_W-1:0];
        else if (side.sq1_ok)
            tone_next = quotient[LANE_SQ1][TONE_W-1:0];
        else if (side.wave_ok)
            tone_next = quotient[LANE_WAVE][TONE_W-1:0];
        else if (side.noise_on)
            tone_next = noise_tone;
        else
            tone_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tone_reg <= tone_next;
        end
    end

    assign tone = tone_reg;

endmodule

`default_nettype wire

// ----- src/dominant_tone_picker.sv -----
// top level of the dominant tone picker: item pipeline, config registers, lanes
`default_nettype none

// picks one buzzer tone in hertz from a snapshot of four sound channels. four
// lanes run side by side (square one, square two, wave, noise), each a
// 23-stage restoring divider that settles one quotient bit per stage, and a
// merge stage picks the winning lane and registers the result. one item is
// accepted every cycle unless a stall backs up to the input; each item passes
// the divider stages and then the output register. every stage has its own
// valid bit, so a stall on the output side only holds the stages that are
// full and empty stages keep taking items. config writes take effect at once
// and should only be made while no item is in flight.
module dominant_tone_picker
    import dtp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // slave side
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // master_on, sq1_active, sq1_volume, sq1_period, sq2_active, sq2_volume,
    // sq2_period, wave_active, wave_period, noise_active, noise_shift,
    // noise_div_code, zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    // master side
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // tone_hz, zero pad
    output logic [OUT_W-1:0]      m_tdata,
    // config write port
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [REG_W-1:0] cfg_data
);

    // divider stages plus the output register
    localparam int NSTG = DIV_STAGES + 1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] en;

    cfg_t  cfg_reg;
    side_t side_in;
    side_t side_reg [DIV_STAGES];
    num_t  dividend [NUM_LANES];
    dvr_t  divisor  [NUM_LANES];
    num_t  quotient [NUM_LANES];
    logic [TONE_W-1:0] tone;

    // a stage can load when it is empty or its content moves on
    always_comb
    begin
        rdy[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign en       = rdy[NSTG-1:0];
    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low  <= BAND_LOW_RST;
            cfg_reg.band_high <= BAND_HIGH_RST;
            cfg_reg.rattle    <= RATTLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BAND_LOW:  cfg_reg.band_low  <= cfg_data;
                CFG_BAND_HIGH: cfg_reg.band_high <= cfg_data;
                CFG_RATTLE:    cfg_reg.rattle    <= cfg_data;
                default:       ;
            endcase
        end
    end

    dtp_prep u_prep (
        .s_tdata  (s_tdata),
        .dividend (dividend),
        .divisor  (divisor),
        .side     (side_in)
    );

    // selection flags travel alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        dtp_div_lane u_lane (
            .clk      (clk),
            .en       (en[DIV_STAGES-1:0]),
            .dividend (dividend[i]),
            .divisor  (divisor[i]),
            .quotient (quotient[i])
        );
    end

    dtp_merge u_merge (
        .clk      (clk),
        .en       (en[NSTG-1]),
        .side     (side_reg[DIV_STAGES-1]),
        .quotient (quotient),
        .cfg      (cfg_reg),
        .tone     (tone)
    );

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {{(OUT_W-TONE_W){1'b0}}, tone};

endmodule

`default_nettype wire

// ----- src/dtp_checker.sv -----
// port-level checks for the dominant tone picker and the bind that attaches them
`default_nettype none

module dtp_checker
    import dtp_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an open output never blocks the input side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input refused while output is open");

    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:TONE_W] == '0)
        else $error("nonzero pad bits on result");

    // the only tone with the top bit set is exactly 2^20
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[TONE_W-1] |-> m_tdata[TONE_W-2:0] == '0)
        else $error("tone above full scale");

endmodule

bind dominant_tone_picker dtp_checker u_dtp_checker (.*);

`default_nettype wire
